@@ sv/lr_pkg.sv @@
package lr_pkg;

  // field widths
  localparam int COORD_WIDTH = 12;
  localparam int COLOR_WIDTH = 24;
  localparam int CFG_WIDTH = 12;
  localparam int CFG_INDEX_WIDTH = 1;

  // |delta| plus sign, error term with headroom for the doubled compare
  localparam int DELTA_WIDTH = COORD_WIDTH + 1;
  localparam int ERR_WIDTH = COORD_WIDTH + 3;
  localparam int CMP_WIDTH = (COORD_WIDTH > CFG_WIDTH) ? COORD_WIDTH : CFG_WIDTH;

  // stream word layouts
  localparam int IN_DATA_BITS = 4 * COORD_WIDTH + COLOR_WIDTH;
  localparam int IN_TDATA_WIDTH = ((IN_DATA_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_BITS = 2 * COORD_WIDTH + COLOR_WIDTH;
  localparam int OUT_TDATA_WIDTH = ((OUT_DATA_BITS + 7) / 8) * 8;

  // screen size after reset
  localparam logic [CFG_WIDTH-1:0] SCREEN_WIDTH_RESET = CFG_WIDTH'(320);
  localparam logic [CFG_WIDTH-1:0] SCREEN_HEIGHT_RESET = CFG_WIDTH'(480);

  typedef logic [COORD_WIDTH-1:0] coord_t;
  typedef logic [COLOR_WIDTH-1:0] color_t;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_STEP = 1'b1
  } opcode_t;

  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    REG_SCREEN_WIDTH = 1'b0,
    REG_SCREEN_HEIGHT = 1'b1
  } cfg_index_t;

  typedef struct packed {
    opcode_t opcode;
    coord_t start_x;
    coord_t start_y;
    coord_t end_x;
    coord_t end_y;
    color_t color;
  } line_item_t;

  typedef struct packed {
    logic [CFG_WIDTH-1:0] width;
    logic [CFG_WIDTH-1:0] height;
  } screen_cfg_t;

  typedef struct packed {
    coord_t pixel_x;
    coord_t pixel_y;
    color_t pixel_color;
    logic visible;
    logic last;
  } pixel_t;

endpackage

@@ sv/line_rasterizer_core.sv @@
// Bresenham line generator, all octants. A load word (tuser = 0) latches two
// endpoints and a color and yields the start point; each step word (tuser = 1)
// yields the next point, tlast marking the endpoint. A step word with no line
// in progress is consumed and yields nothing. Output tuser flags a point that
// lies inside the programmed screen width and height. One word is taken every
// clock while s_tready is high: the whole error update and point compare run
// combinationally from the line registers, and each point is registered in a
// two-word output buffer that keeps the input open for one more word during an
// output stall; s_tready drops only while both output words are held.
module line_rasterizer_core (
  input  logic                                clk,
  input  logic                                rst,
  // input words
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // start_x, start_y, end_x, end_y, color
  input  logic [lr_pkg::IN_TDATA_WIDTH-1:0]   s_tdata,
  // opcode
  input  logic                                s_tuser,
  // output points
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // pixel_x, pixel_y, pixel_color
  output logic [lr_pkg::OUT_TDATA_WIDTH-1:0]  m_tdata,
  // visible
  output logic                                m_tuser,
  output logic                                m_tlast,
  // register writes
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [lr_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
  input  logic [lr_pkg::CFG_WIDTH-1:0]        cfg_data
);
  import lr_pkg::*;

  screen_cfg_t screen;
  line_item_t item;
  logic accept;
  logic res_valid;
  pixel_t res;

  logic out_valid;
  pixel_t out_word;
  logic skid_valid;
  pixel_t skid_word;
  logic take;

  // screen size registers
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      screen.width <= SCREEN_WIDTH_RESET;
      screen.height <= SCREEN_HEIGHT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_SCREEN_WIDTH:  screen.width <= cfg_data;
        REG_SCREEN_HEIGHT: screen.height <= cfg_data;
        default: ;
      endcase
    end
  end

  // unpack the input word
  always_comb begin
    item.opcode = opcode_t'(s_tuser);
    item.start_x = s_tdata[0*COORD_WIDTH +: COORD_WIDTH];
    item.start_y = s_tdata[1*COORD_WIDTH +: COORD_WIDTH];
    item.end_x = s_tdata[2*COORD_WIDTH +: COORD_WIDTH];
    item.end_y = s_tdata[3*COORD_WIDTH +: COORD_WIDTH];
    item.color = s_tdata[4*COORD_WIDTH +: COLOR_WIDTH];
  end

  assign s_tready = !skid_valid;
  assign accept = s_tvalid && s_tready;

  lr_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .item      (item),
    .screen    (screen),
    .res_valid (res_valid),
    .res       (res)
  );

  // two-word output buffer
  assign take = out_valid && m_tready;
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || take) begin
      if (skid_valid) begin
        out_valid <= 1'b1;
        out_word <= skid_word;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= res_valid;
        out_word <= res;
      end
    end else if (res_valid) begin
      skid_valid <= 1'b1;
      skid_word <= res;
    end
  end

  // pack the output word
  assign m_tvalid = out_valid;
  assign m_tdata = OUT_TDATA_WIDTH'({out_word.pixel_color, out_word.pixel_y, out_word.pixel_x});
  assign m_tuser = out_word.visible;
  assign m_tlast = out_word.last;

  // the spare word is only held behind a full output register
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("spare word held with empty output register");

  // a point arriving during a stall is parked, not dropped
  a_stall_parks: assert property (@(posedge clk) disable iff (rst)
    out_valid && !m_tready && res_valid |=> skid_valid)
    else $error("point lost during output stall");

  // the spare word fills only while the output stalls
  a_skid_fill_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_valid) |-> $past(out_valid && !m_tready && res_valid))
    else $error("spare word filled without a stall");

endmodule

@@ sv/lr_engine.sv @@
module lr_engine (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 accept,
  input  lr_pkg::line_item_t   item,
  input  lr_pkg::screen_cfg_t  screen,
  output logic                 res_valid,
  output lr_pkg::pixel_t       res
);
  import lr_pkg::*;

  // line state
  coord_t cur_x;
  coord_t cur_y;
  coord_t goal_x;
  coord_t goal_y;
  logic signed [DELTA_WIDTH-1:0] abs_dx;
  logic signed [DELTA_WIDTH-1:0] neg_abs_dy;
  logic signed [ERR_WIDTH-1:0] error_term;
  logic step_x_negative;
  logic step_y_negative;
  logic line_active;
  color_t line_color;

  coord_t cur_x_next;
  coord_t cur_y_next;
  coord_t goal_x_next;
  coord_t goal_y_next;
  logic signed [DELTA_WIDTH-1:0] abs_dx_next;
  logic signed [DELTA_WIDTH-1:0] neg_abs_dy_next;
  logic signed [ERR_WIDTH-1:0] error_term_next;
  logic step_x_negative_next;
  logic step_y_negative_next;
  color_t line_color_next;

  logic is_load;
  coord_t ld_dx;
  coord_t ld_dy;
  logic signed [ERR_WIDTH:0] e2;
  logic take_x;
  logic take_y;
  logic at_end;

  always_comb begin
    is_load = (item.opcode == OP_LOAD);

    // load: deltas, directions and initial error
    ld_dx = (item.end_x >= item.start_x) ? item.end_x - item.start_x
                                         : item.start_x - item.end_x;
    ld_dy = (item.end_y >= item.start_y) ? item.end_y - item.start_y
                                         : item.start_y - item.end_y;

    // step: the two-compare update on the doubled error
    e2 = {error_term, 1'b0};
    take_x = (e2 >= (ERR_WIDTH+1)'(neg_abs_dy));
    take_y = (e2 <= (ERR_WIDTH+1)'(abs_dx));

    if (is_load) begin
      cur_x_next = item.start_x;
      cur_y_next = item.start_y;
      goal_x_next = item.end_x;
      goal_y_next = item.end_y;
      step_x_negative_next = !(item.start_x < item.end_x);
      step_y_negative_next = !(item.start_y < item.end_y);
      abs_dx_next = $signed({1'b0, ld_dx});
      neg_abs_dy_next = $signed(DELTA_WIDTH'(0) - {1'b0, ld_dy});
      error_term_next = ERR_WIDTH'(abs_dx_next) + ERR_WIDTH'(neg_abs_dy_next);
      line_color_next = item.color;
    end else begin
      cur_x_next = cur_x;
      cur_y_next = cur_y;
      goal_x_next = goal_x;
      goal_y_next = goal_y;
      step_x_negative_next = step_x_negative;
      step_y_negative_next = step_y_negative;
      abs_dx_next = abs_dx;
      neg_abs_dy_next = neg_abs_dy;
      error_term_next = error_term
                      + (take_x ? ERR_WIDTH'(neg_abs_dy) : ERR_WIDTH'(0))
                      + (take_y ? ERR_WIDTH'(abs_dx) : ERR_WIDTH'(0));
      line_color_next = line_color;
      if (take_x) begin
        cur_x_next = step_x_negative ? cur_x - COORD_WIDTH'(1) : cur_x + COORD_WIDTH'(1);
      end
      if (take_y) begin
        cur_y_next = step_y_negative ? cur_y - COORD_WIDTH'(1) : cur_y + COORD_WIDTH'(1);
      end
    end

    // emitted point
    at_end = (cur_x_next == goal_x_next) && (cur_y_next == goal_y_next);
    res_valid = accept && (is_load || line_active);
    res.pixel_x = cur_x_next;
    res.pixel_y = cur_y_next;
    res.pixel_color = line_color_next;
    res.visible = (CMP_WIDTH'(cur_x_next) < CMP_WIDTH'(screen.width))
               && (CMP_WIDTH'(cur_y_next) < CMP_WIDTH'(screen.height));
    res.last = at_end;
  end

  // active flag
  always_ff @(posedge clk) begin
    if (rst) begin
      line_active <= 1'b0;
    end else if (res_valid) begin
      line_active <= !at_end;
    end
  end

  // line registers
  always_ff @(posedge clk) begin
    if (res_valid) begin
      cur_x <= cur_x_next;
      cur_y <= cur_y_next;
      goal_x <= goal_x_next;
      goal_y <= goal_y_next;
      abs_dx <= abs_dx_next;
      neg_abs_dy <= neg_abs_dy_next;
      error_term <= error_term_next;
      step_x_negative <= step_x_negative_next;
      step_y_negative <= step_y_negative_next;
      line_color <= line_color_next;
    end
  end

  // the endpoint ends the line
  a_last_ends_line: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.last |=> !line_active)
    else $error("line still active after its endpoint");

  // an active line never sits on its endpoint
  a_active_not_at_goal: assert property (@(posedge clk) disable iff (rst)
    line_active |-> (cur_x != goal_x) || (cur_y != goal_y))
    else $error("active line already at its endpoint");

  // only a load starts a line
  a_rise_from_load: assert property (@(posedge clk) disable iff (rst)
    $rose(line_active) |-> $past(accept && item.opcode == OP_LOAD))
    else $error("line became active without a load");

endmodule

@@ tb/line_rasterizer_core_test.sv @@
module line_rasterizer_core_test;

  import lr_pkg::*;

  localparam int TIMEOUT = 10_000_000;
  localparam int MAX_PRINTS = 40;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [IN_TDATA_WIDTH-1:0] s_tdata = '0;
  logic s_tuser = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [OUT_TDATA_WIDTH-1:0] m_tdata;
  logic m_tuser;
  logic m_tlast;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
  logic [CFG_WIDTH-1:0] cfg_data = '0;

  line_rasterizer_core i_dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser),
    .m_tlast(m_tlast),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  // words waiting to go in and points still owed by the block
  line_item_t line_words[$];
  pixel_t expected_pixels[$];
  int mismatch_count = 0;

  // line state as the block should hold it
  coord_t pen_x = '0, pen_y = '0, goal_x = '0, goal_y = '0;
  logic [DELTA_WIDTH-1:0] run_x = '0;
  logic signed [DELTA_WIDTH-1:0] neg_rise_y = '0;
  logic signed [ERR_WIDTH-1:0] slope_err = '0;
  logic x_backward = 1'b0, y_backward = 1'b0, line_live = 1'b0;
  color_t line_ink = '0;
  logic [CFG_WIDTH-1:0] clip_w = SCREEN_WIDTH_RESET;
  logic [CFG_WIDTH-1:0] clip_h = SCREEN_HEIGHT_RESET;

  // sender and receiver pacing
  int burst_left = 0;
  int gap_left = 0;
  int words_accepted = 0;
  int words_seen = 0;
  logic [15:0] ready_pattern = 16'hffff;
  int ready_phase = 0;

  task automatic report_mismatch(input string msg);
    if (mismatch_count < MAX_PRINTS)
      $display("[%0t] mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  // bresenham update for one accepted word, queueing the point it yields
  task automatic trace_line_word(input line_item_t w);
    int e, e2, rise;
    bit yields;
    pixel_t p;
    yields = 1'b0;
    if (w.opcode == OP_LOAD) begin
      pen_x = w.start_x;
      pen_y = w.start_y;
      goal_x = w.end_x;
      goal_y = w.end_y;
      x_backward = !(w.start_x < w.end_x);
      y_backward = !(w.start_y < w.end_y);
      run_x = (w.end_x >= w.start_x) ? DELTA_WIDTH'(w.end_x - w.start_x)
                                     : DELTA_WIDTH'(w.start_x - w.end_x);
      rise = (w.end_y >= w.start_y) ? int'(w.end_y - w.start_y) : int'(w.start_y - w.end_y);
      neg_rise_y = DELTA_WIDTH'(-rise);
      slope_err = ERR_WIDTH'(int'(run_x) + int'(neg_rise_y));
      line_ink = w.color;
      line_live = 1'b1;
      yields = 1'b1;
    end else if (line_live) begin
      e = int'(slope_err);
      e2 = 2 * e;
      if (e2 >= int'(neg_rise_y)) begin
        e += int'(neg_rise_y);
        pen_x = x_backward ? pen_x - 1'b1 : pen_x + 1'b1;
      end
      if (e2 <= int'(run_x)) begin
        e += int'(run_x);
        pen_y = y_backward ? pen_y - 1'b1 : pen_y + 1'b1;
      end
      slope_err = ERR_WIDTH'(e);
      yields = 1'b1;
    end
    if (yields) begin
      p.pixel_x = pen_x;
      p.pixel_y = pen_y;
      p.pixel_color = line_ink;
      p.visible = (CMP_WIDTH'(pen_x) < CMP_WIDTH'(clip_w)) &&
                  (CMP_WIDTH'(pen_y) < CMP_WIDTH'(clip_h));
      p.last = (pen_x == goal_x) && (pen_y == goal_y);
      if (p.last)
        line_live = 1'b0;
      expected_pixels.push_back(p);
    end
  endtask

  // input acceptance, then output check
  always @(posedge clk) begin
    pixel_t want;
    if (!rst && s_tvalid && s_tready) begin
      trace_line_word(line_words.pop_front());
      words_accepted++;
    end
    if (!rst && m_tvalid && m_tready) begin
      if (expected_pixels.size() == 0) begin
        report_mismatch($sformatf("unexpected point x=%0d y=%0d",
                                  m_tdata[COORD_WIDTH-1:0],
                                  m_tdata[2*COORD_WIDTH-1:COORD_WIDTH]));
      end else begin
        want = expected_pixels.pop_front();
        if (m_tdata[COORD_WIDTH-1:0] !== want.pixel_x)
          report_mismatch($sformatf("pixel_x got %0d expected %0d",
                                    m_tdata[COORD_WIDTH-1:0], want.pixel_x));
        if (m_tdata[2*COORD_WIDTH-1:COORD_WIDTH] !== want.pixel_y)
          report_mismatch($sformatf("pixel_y got %0d expected %0d",
                                    m_tdata[2*COORD_WIDTH-1:COORD_WIDTH], want.pixel_y));
        if (m_tdata[2*COORD_WIDTH+COLOR_WIDTH-1:2*COORD_WIDTH] !== want.pixel_color)
          report_mismatch($sformatf("pixel_color got %0h expected %0h",
                                    m_tdata[2*COORD_WIDTH+COLOR_WIDTH-1:2*COORD_WIDTH],
                                    want.pixel_color));
        if (m_tuser !== want.visible)
          report_mismatch($sformatf("visible got %b expected %b at x=%0d y=%0d",
                                    m_tuser, want.visible, want.pixel_x, want.pixel_y));
        if (m_tlast !== want.last)
          report_mismatch($sformatf("last got %b expected %b at x=%0d y=%0d",
                                    m_tlast, want.last, want.pixel_x, want.pixel_y));
      end
    end
  end

  // sender: bursts of words with random gaps
  always @(negedge clk) begin
    line_item_t nxt;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || words_seen != words_accepted) begin
      words_seen = words_accepted;
      if (gap_left > 0) begin
        gap_left--;
        s_tvalid <= 1'b0;
      end else if (line_words.size() > 0) begin
        nxt = line_words[0];
        s_tvalid <= 1'b1;
        s_tuser <= nxt.opcode;
        s_tdata <= {nxt.color, nxt.end_y, nxt.end_x, nxt.start_y, nxt.start_x};
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 40);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
        end
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // receiver: ready follows a random 16-bit stall pattern, redrawn in one of four styles
  always @(negedge clk) begin
    if (ready_phase % 64 == 0) begin
      case ($urandom_range(0, 3))
        0: ready_pattern = 16'hffff;
        1: ready_pattern = 16'($urandom);
        2: ready_pattern = 16'($urandom) | 16'($urandom);
        default: ready_pattern = 16'($urandom) & 16'($urandom);
      endcase
    end
    m_tready <= ready_pattern[ready_phase % 16];
    ready_phase++;
  end

  task automatic write_screen_reg(input cfg_index_t idx, input int value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_WIDTH'(value);
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_SCREEN_WIDTH)
      clip_w = CFG_WIDTH'(value);
    else
      clip_h = CFG_WIDTH'(value);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic push_word(input opcode_t op, input int sx, input int sy,
                           input int ex, input int ey, input int unsigned col);
    line_item_t w;
    w.opcode = op;
    w.start_x = coord_t'(sx);
    w.start_y = coord_t'(sy);
    w.end_x = coord_t'(ex);
    w.end_y = coord_t'(ey);
    w.color = color_t'(col);
    line_words.push_back(w);
  endtask

  // step words carry junk in the unused fields
  task automatic push_steps(input int n);
    repeat (n)
      push_word(OP_STEP, $urandom, $urandom, $urandom, $urandom, $urandom);
  endtask

  // one random line: mostly short and run to the end, some dropped midway
  task automatic queue_random_line(input int w, input int h, inout int words);
    int sx, sy, ex, ey, ax, ay, span, steps, kind;
    kind = $urandom_range(0, 9);
    if ($urandom_range(0, 1) == 1) begin
      sx = $urandom_range(0, (w + 16 > 4095) ? 4095 : w + 16);
      sy = $urandom_range(0, (h + 16 > 4095) ? 4095 : h + 16);
    end else begin
      sx = $urandom_range(0, 4095);
      sy = $urandom_range(0, 4095);
    end
    if (kind < 8) begin
      ex = sx + $urandom_range(0, 24) - 12;
      ey = sy + $urandom_range(0, 24) - 12;
    end else if (kind == 8) begin
      ex = sx + $urandom_range(0, 400) - 200;
      ey = sy + $urandom_range(0, 400) - 200;
    end else begin
      ex = $urandom_range(0, 4095);
      ey = $urandom_range(0, 4095);
    end
    ex = (ex < 0) ? 0 : (ex > 4095) ? 4095 : ex;
    ey = (ey < 0) ? 0 : (ey > 4095) ? 4095 : ey;
    ax = (ex > sx) ? ex - sx : sx - ex;
    ay = (ey > sy) ? ey - sy : sy - ey;
    span = (ax > ay) ? ax : ay;
    steps = span;
    if (span > 300 || $urandom_range(0, 7) == 0)
      steps = $urandom_range(0, (span > 40) ? 40 : span);
    push_word(OP_LOAD, sx, sy, ex, ey, $urandom);
    push_steps(steps);
    words += 1 + steps;
    // stray steps after the endpoint are swallowed
    if (steps == span && $urandom_range(0, 5) == 0)
      push_steps($urandom_range(1, 2));
  endtask

  task automatic queue_random_lines(input int w, input int h, input int quota);
    int words;
    words = 0;
    while (words < quota)
      queue_random_line(w, h, words);
  endtask

  // wait until every word is in and every point is out
  task automatic drain();
    int waited;
    waited = 0;
    while ((line_words.size() > 0 || expected_pixels.size() > 0) && waited < 50000) begin
      @(negedge clk);
      waited++;
    end
    repeat (10) @(negedge clk);
    if (expected_pixels.size() > 0) begin
      report_mismatch($sformatf("%0d points never arrived", expected_pixels.size()));
      expected_pixels.delete();
    end
  endtask

  task automatic run_screen(input int w, input int h, input int quota);
    write_screen_reg(REG_SCREEN_WIDTH, w);
    write_screen_reg(REG_SCREEN_HEIGHT, h);
    queue_random_lines(w, h, quota);
    drain();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed lines at the reset screen size
    push_steps(1);                                  // nothing drawing yet
    push_word(OP_LOAD, 0, 0, 0, 0, 0);              // single point at origin
    push_steps(1);
    push_word(OP_LOAD, 4095, 4095, 4095, 4095, 24'hffffff);
    push_word(OP_LOAD, 10, 5, 14, 7, 24'h123456);   // shallow line to its end
    push_steps(4);
    push_steps(1);                                  // past the endpoint
    push_word(OP_LOAD, 4095, 0, 0, 4095, 24'ha5a5a5);
    push_steps(2);                                  // dropped by the next load
    push_word(OP_LOAD, 3, 9, 1, 3, 24'h5a5a5a);     // steep, both axes backward
    push_steps(6);
    push_word(OP_LOAD, 318, 479, 321, 481, 24'h00ff00); // across the clip edges
    push_steps(3);
    drain();
    queue_random_lines(SCREEN_WIDTH_RESET, SCREEN_HEIGHT_RESET, 300);
    drain();

    run_screen(4095, 4095, 300);
    run_screen(1, 1, 200);
    run_screen(0, 4095, 150);                       // zero width clips everything
    run_screen($urandom_range(1, 4095), $urandom_range(1, 4095), 300);
    run_screen($urandom_range(1, 4095), $urandom_range(1, 4095), 300);
    run_screen($urandom_range(16, 640), 4095, 250);

    if (mismatch_count == 0) begin
      $display("** line_rasterizer_core: PASSED **");
    end else begin
      $display("** line_rasterizer_core: FAILED **");
    end
    $finish;
  end

  initial begin
    #TIMEOUT;
    $display("** line_rasterizer_core: FAILED **");
    $finish;
  end

endmodule

@@ sim.f @@
sv/lr_pkg.sv
sv/lr_engine.sv
sv/line_rasterizer_core.sv
tb/line_rasterizer_core_test.sv
